FILE: rtl/lbdc_pkg.sv
// ============================================================================
// LED blink and dimming controller package
// Shared widths, command codes, register indexes and the lightness table.
// ============================================================================
package lbdc_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int CHAN_W           = 8;
    localparam int TIME_W           = 16;
    localparam int LEVEL_W          = 7;
    localparam int OPCODE_W         = 3;
    localparam int IN_DATA_W        = 56;
    localparam int OUT_DATA_W       = 8;
    localparam int APB_ADDR_W       = 4;
    localparam int APB_DATA_W       = 32;

    localparam logic [LEVEL_W-1:0] PCT_MAX = 7'd100;

    localparam logic [OPCODE_W-1:0] OP_ON         = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_OFF        = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_TOGGLE     = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_BLINK      = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_BRIGHTNESS = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_TICK       = 3'd5;

    localparam logic [1:0] REG_TICKS_PER_MS   = 2'd0;
    localparam logic [1:0] REG_CHANNEL_ENABLE = 2'd1;
    localparam logic [1:0] REG_ON_LEVEL       = 2'd2;

    localparam logic [TIME_W-1:0] TICKS_PER_MS_RST   = 16'd10;
    localparam logic [CHAN_W-1:0] CHANNEL_ENABLE_RST = 8'hFF;

    localparam logic [LEVEL_W-1:0] LIGHTNESS [0:100] = '{
        7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,
        7'd1,  7'd1,  7'd1,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd3,  7'd3,
        7'd3,  7'd3,  7'd4,  7'd4,  7'd4,  7'd4,  7'd5,  7'd5,  7'd5,  7'd6,
        7'd6,  7'd7,  7'd7,  7'd8,  7'd8,  7'd8,  7'd9,  7'd10, 7'd10, 7'd11,
        7'd11, 7'd12, 7'd12, 7'd13, 7'd14, 7'd15, 7'd15, 7'd16, 7'd17, 7'd18,
        7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25, 7'd26, 7'd27,
        7'd28, 7'd29, 7'd30, 7'd32, 7'd33, 7'd34, 7'd35, 7'd37, 7'd38, 7'd39,
        7'd41, 7'd42, 7'd44, 7'd45, 7'd47, 7'd48, 7'd50, 7'd52, 7'd53, 7'd55,
        7'd57, 7'd58, 7'd60, 7'd62, 7'd64, 7'd66, 7'd68, 7'd70, 7'd72, 7'd74,
        7'd76, 7'd78, 7'd81, 7'd83, 7'd85, 7'd88, 7'd90, 7'd92, 7'd95, 7'd97,
        7'd100
    };

    // Saturates the percentage and looks up the PWM duty.
    function automatic logic [LEVEL_W-1:0] duty_of(input logic [LEVEL_W-1:0] level);
        logic [LEVEL_W-1:0] idx;
        idx = (level > PCT_MAX) ? PCT_MAX : level;
        return LIGHTNESS[idx];
    endfunction

endpackage

FILE: rtl/led_blink_dimming_controller.sv
// ============================================================================
// LED blink and dimming controller
// Multi-channel LED on, off, toggle, blink and software PWM dimming.
// ============================================================================
// Each item passes an input register, one pass of per-channel update logic,
// and the result register. Throughput: one item per cycle while the result
// side takes results; a stalled result holds the item in the input register.
// Reset clears all channel state, the prescaler and both valid flags, and
// loads the register defaults.
module led_blink_dimming_controller
    import lbdc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // opcode[2:0], channel_mask[10:3], blink_on_ms[26:11],
    // blink_off_ms[42:27], brightness_level[49:43], zero fill[55:50]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pin_levels[7:0]
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [TIME_W-1:0]  ticks_per_ms_reg;
    logic [CHAN_W-1:0]  channel_enable_reg;
    logic               on_level_reg;

    logic                in_valid_reg;
    logic [OPCODE_W-1:0] op_reg;
    logic [CHAN_W-1:0]   mask_reg;
    logic [TIME_W-1:0]   t_on_reg;
    logic [TIME_W-1:0]   t_off_reg;
    logic [LEVEL_W-1:0]  level_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] pins_reg;
    logic [OUT_DATA_W-1:0] pins_next;

    logic [TIME_W-1:0] prescale_reg;
    logic [TIME_W-1:0] prescale_next;
    logic              strobe;

    logic               lit_reg      [NUM_CHANNELS];
    logic               lit_next     [NUM_CHANNELS];
    logic               blinking_reg [NUM_CHANNELS];
    logic               blinking_next[NUM_CHANNELS];
    logic               phase_on_reg [NUM_CHANNELS];
    logic               phase_on_next[NUM_CHANNELS];
    logic               dimming_reg  [NUM_CHANNELS];
    logic               dimming_next [NUM_CHANNELS];
    logic [TIME_W-1:0]  on_per_reg   [NUM_CHANNELS];
    logic [TIME_W-1:0]  on_per_next  [NUM_CHANNELS];
    logic [TIME_W-1:0]  off_per_reg  [NUM_CHANNELS];
    logic [TIME_W-1:0]  off_per_next [NUM_CHANNELS];
    logic [TIME_W-1:0]  phase_cnt_reg[NUM_CHANNELS];
    logic [TIME_W-1:0]  phase_cnt_next[NUM_CHANNELS];
    logic [LEVEL_W-1:0] pwm_cnt_reg  [NUM_CHANNELS];
    logic [LEVEL_W-1:0] pwm_cnt_next [NUM_CHANNELS];
    logic [LEVEL_W-1:0] duty_reg     [NUM_CHANNELS];
    logic [LEVEL_W-1:0] duty_next    [NUM_CHANNELS];

    logic [CHAN_W-1:0]  sel;
    logic [LEVEL_W-1:0] cmd_duty;
    logic               advance;
    logic               cfg_write;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pins_reg;
    assign pready   = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TICKS_PER_MS:   prdata = {{(APB_DATA_W-TIME_W){1'b0}}, ticks_per_ms_reg};
            REG_CHANNEL_ENABLE: prdata = {{(APB_DATA_W-CHAN_W){1'b0}}, channel_enable_reg};
            REG_ON_LEVEL:       prdata = {{(APB_DATA_W-1){1'b0}}, on_level_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_ms_reg   <= TICKS_PER_MS_RST;
            channel_enable_reg <= CHANNEL_ENABLE_RST;
            on_level_reg       <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_TICKS_PER_MS:   ticks_per_ms_reg   <= pwdata[TIME_W-1:0];
                REG_CHANNEL_ENABLE: channel_enable_reg <= pwdata[CHAN_W-1:0];
                REG_ON_LEVEL:       on_level_reg       <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg    <= s_tdata[2:0];
            mask_reg  <= s_tdata[10:3];
            t_on_reg  <= s_tdata[26:11];
            t_off_reg <= s_tdata[42:27];
            level_reg <= s_tdata[49:43];
        end
        if (advance)
        begin
            pins_reg <= pins_next;
        end
    end

    always_comb
    begin
        logic [LEVEL_W-1:0] lvl;
        lvl      = (level_reg > PCT_MAX) ? PCT_MAX : level_reg;
        cmd_duty = LIGHTNESS[lvl];
        sel      = mask_reg & channel_enable_reg;
        prescale_next = prescale_reg;
        strobe        = 1'b0;
        if (op_reg == OP_TICK)
        begin
            prescale_next = prescale_reg + 16'd1;
            if (prescale_next >= ticks_per_ms_reg)
            begin
                prescale_next = '0;
                strobe        = 1'b1;
            end
        end
    end

    always_comb
    begin
        logic [TIME_W-1:0]  pc_dec;
        logic [LEVEL_W-1:0] pwm_dec;
        logic               swapped;
        pins_next = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            lit_next[c]       = lit_reg[c];
            blinking_next[c]  = blinking_reg[c];
            phase_on_next[c]  = phase_on_reg[c];
            dimming_next[c]   = dimming_reg[c];
            on_per_next[c]    = on_per_reg[c];
            off_per_next[c]   = off_per_reg[c];
            phase_cnt_next[c] = phase_cnt_reg[c];
            pwm_cnt_next[c]   = pwm_cnt_reg[c];
            duty_next[c]      = duty_reg[c];
            pc_dec  = (phase_cnt_reg[c] != '0) ? phase_cnt_reg[c] - 16'd1 : '0;
            pwm_dec = (pwm_cnt_reg[c] != '0) ? pwm_cnt_reg[c] - 7'd1 : '0;
            swapped = 1'b0;
            case (op_reg) inside
                OP_ON, OP_OFF, OP_TOGGLE:
                begin
                    if (sel[c])
                    begin
                        blinking_next[c] = 1'b0;
                        dimming_next[c]  = 1'b0;
                        if (op_reg == OP_ON)
                            lit_next[c] = 1'b1;
                        else if (op_reg == OP_OFF)
                            lit_next[c] = 1'b0;
                        else
                            lit_next[c] = !lit_reg[c];
                    end
                end
                OP_BLINK:
                begin
                    if (sel[c])
                    begin
                        if (t_on_reg == '0 || t_off_reg == '0)
                        begin
                            blinking_next[c] = 1'b0;
                        end
                        else
                        begin
                            on_per_next[c]    = t_on_reg;
                            off_per_next[c]   = t_off_reg;
                            phase_on_next[c]  = lit_reg[c];
                            phase_cnt_next[c] = lit_reg[c] ? t_on_reg : t_off_reg;
                            blinking_next[c]  = 1'b1;
                        end
                    end
                end
                OP_BRIGHTNESS:
                begin
                    if (sel[c])
                    begin
                        if (cmd_duty == '0)
                            lit_next[c] = 1'b0;
                        else if (cmd_duty >= PCT_MAX)
                            lit_next[c] = 1'b1;
                        pwm_cnt_next[c] = '0;
                        duty_next[c]    = cmd_duty;
                        dimming_next[c] = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    if (channel_enable_reg[c])
                    begin
                        if (blinking_reg[c] && strobe)
                        begin
                            phase_cnt_next[c] = pc_dec;
                            if (pc_dec == '0)
                            begin
                                swapped          = 1'b1;
                                lit_next[c]      = !phase_on_reg[c];
                                phase_cnt_next[c] = phase_on_reg[c] ? off_per_reg[c]
                                                                    : on_per_reg[c];
                                phase_on_next[c] = !phase_on_reg[c];
                            end
                        end
                        if (!swapped && dimming_reg[c]
                            && (!blinking_reg[c] || phase_on_reg[c]))
                        begin
                            pwm_cnt_next[c] = pwm_dec;
                            if (pwm_dec == '0)
                            begin
                                pwm_cnt_next[c] = lit_reg[c] ? PCT_MAX - duty_reg[c]
                                                             : duty_reg[c];
                                if (pwm_cnt_next[c] != '0 && pwm_cnt_next[c] < PCT_MAX)
                                    lit_next[c] = !lit_reg[c];
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (channel_enable_reg[c])
                pins_next[c] = on_level_reg ? lit_next[c] : !lit_next[c];
            else
                pins_next[c] = !on_level_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prescale_reg  <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                lit_reg[c]       <= 1'b0;
                blinking_reg[c]  <= 1'b0;
                phase_on_reg[c]  <= 1'b0;
                dimming_reg[c]   <= 1'b0;
                on_per_reg[c]    <= '0;
                off_per_reg[c]   <= '0;
                phase_cnt_reg[c] <= '0;
                pwm_cnt_reg[c]   <= '0;
                duty_reg[c]      <= '0;
            end
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                prescale_reg <= prescale_next;
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    lit_reg[c]       <= lit_next[c];
                    blinking_reg[c]  <= blinking_next[c];
                    phase_on_reg[c]  <= phase_on_next[c];
                    dimming_reg[c]   <= dimming_next[c];
                    on_per_reg[c]    <= on_per_next[c];
                    off_per_reg[c]   <= off_per_next[c];
                    phase_cnt_reg[c] <= phase_cnt_next[c];
                    pwm_cnt_reg[c]   <= pwm_cnt_next[c];
                    duty_reg[c]      <= duty_next[c];
                end
            end
        end
    end

endmodule

FILE: rtl/lbdc_checker.sv
// ============================================================================
// LED blink and dimming controller checker
// Port-level checks on the result stream and the register port.
// ============================================================================
module lbdc_checker
    import lbdc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready
);

    localparam logic [OUT_DATA_W-1:0] CHAN_MASK = OUT_DATA_W'((1 << NUM_CHANNELS) - 1);

    logic wr;
    assign wr = psel && penable && pwrite && pready;

    // A result that is held back keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Pins beyond the channel count never drive.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata & ~CHAN_MASK) == '0)
        else $error("pin level set above channel count");

    // With the result side empty the input side must take an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // A polarity write reads back on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr && paddr[3:2] == REG_ON_LEVEL)
        ##1 (psel && !pwrite && paddr[3:2] == REG_ON_LEVEL)
        |-> prdata == {{(APB_DATA_W-1){1'b0}}, $past(pwdata[0])})
        else $error("polarity register read back mismatch");

    // A prescaler write reads back on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr && paddr[3:2] == REG_TICKS_PER_MS)
        ##1 (psel && !pwrite && paddr[3:2] == REG_TICKS_PER_MS)
        |-> prdata == {{(APB_DATA_W-TIME_W){1'b0}}, $past(pwdata[TIME_W-1:0])})
        else $error("prescaler register read back mismatch");

endmodule

bind led_blink_dimming_controller lbdc_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_lbdc_checker (.*);

FILE: dv/led_blink_dimming_controller_checker.sv
// ============================================================================
// LED blink and dimming controller checker
// Watches the command, result and register channels, keeps its own model of
// every LED channel, predicts the pin levels for each accepted item and
// compares them with the results in order of arrival.
// ============================================================================
module led_blink_dimming_controller_checker
    import lbdc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    mismatches,
    output int                    pending_results,
    output int                    results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [LEVEL_W-1:0] CIE_DUTY [0:100] = '{
        7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,
        7'd1,  7'd1,  7'd1,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd3,  7'd3,
        7'd3,  7'd3,  7'd4,  7'd4,  7'd4,  7'd4,  7'd5,  7'd5,  7'd5,  7'd6,
        7'd6,  7'd7,  7'd7,  7'd8,  7'd8,  7'd8,  7'd9,  7'd10, 7'd10, 7'd11,
        7'd11, 7'd12, 7'd12, 7'd13, 7'd14, 7'd15, 7'd15, 7'd16, 7'd17, 7'd18,
        7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25, 7'd26, 7'd27,
        7'd28, 7'd29, 7'd30, 7'd32, 7'd33, 7'd34, 7'd35, 7'd37, 7'd38, 7'd39,
        7'd41, 7'd42, 7'd44, 7'd45, 7'd47, 7'd48, 7'd50, 7'd52, 7'd53, 7'd55,
        7'd57, 7'd58, 7'd60, 7'd62, 7'd64, 7'd66, 7'd68, 7'd70, 7'd72, 7'd74,
        7'd76, 7'd78, 7'd81, 7'd83, 7'd85, 7'd88, 7'd90, 7'd92, 7'd95, 7'd97,
        7'd100
    };

    logic [TIME_W-1:0]       tick_divider;
    logic [CHAN_W-1:0]       chan_enable;
    logic                    lit_level;
    logic [TIME_W-1:0]       prescale;
    logic [NUM_CHANNELS-1:0] lit;
    logic [NUM_CHANNELS-1:0] blinking;
    logic [NUM_CHANNELS-1:0] phase_on;
    logic [NUM_CHANNELS-1:0] dimming;
    logic [TIME_W-1:0]       on_ms      [NUM_CHANNELS];
    logic [TIME_W-1:0]       off_ms     [NUM_CHANNELS];
    logic [TIME_W-1:0]       phase_left [NUM_CHANNELS];
    logic [LEVEL_W-1:0]      pwm_left   [NUM_CHANNELS];
    logic [LEVEL_W-1:0]      level_idx  [NUM_CHANNELS];

    logic [OUT_DATA_W-1:0]   expected_pins [$];
    logic [OUT_DATA_W-1:0]   predicted;
    logic [OUT_DATA_W-1:0]   wanted;
    int                      fail_total;
    int                      seen_total;

    task automatic predict_pins(input logic [IN_DATA_W-1:0] item,
                                output logic [OUT_DATA_W-1:0] pins);
        logic [OPCODE_W-1:0] op;
        logic [CHAN_W-1:0]   sel;
        logic [TIME_W-1:0]   t_on;
        logic [TIME_W-1:0]   t_off;
        logic [LEVEL_W-1:0]  lvl;
        logic [LEVEL_W-1:0]  duty;
        logic                strobe;
        logic                swapped;
        op     = item[2:0];
        sel    = item[10:3] & chan_enable;
        t_on   = item[26:11];
        t_off  = item[42:27];
        lvl    = item[49:43];
        pins   = '0;
        strobe = 1'b0;
        if (lvl > PCT_MAX)
        begin
            lvl = PCT_MAX;
        end
        if (op == OP_TICK)
        begin
            prescale = prescale + 16'd1;
            if (prescale >= tick_divider)
            begin
                prescale = '0;
                strobe   = 1'b1;
            end
        end
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if ((op == OP_ON || op == OP_OFF || op == OP_TOGGLE) && sel[c])
            begin
                blinking[c] = 1'b0;
                dimming[c]  = 1'b0;
                if (op == OP_ON)
                begin
                    lit[c] = 1'b1;
                end
                else if (op == OP_OFF)
                begin
                    lit[c] = 1'b0;
                end
                else
                begin
                    lit[c] = ~lit[c];
                end
            end
            else if (op == OP_BLINK && sel[c])
            begin
                if (t_on == '0 || t_off == '0)
                begin
                    blinking[c] = 1'b0;
                end
                else
                begin
                    on_ms[c]      = t_on;
                    off_ms[c]     = t_off;
                    phase_on[c]   = lit[c];
                    phase_left[c] = lit[c] ? t_on : t_off;
                    blinking[c]   = 1'b1;
                end
            end
            else if (op == OP_BRIGHTNESS && sel[c])
            begin
                duty = CIE_DUTY[lvl];
                if (duty == '0)
                begin
                    lit[c] = 1'b0;
                end
                else if (duty >= PCT_MAX)
                begin
                    lit[c] = 1'b1;
                end
                pwm_left[c]  = '0;
                level_idx[c] = lvl;
                dimming[c]   = 1'b1;
            end
            else if (op == OP_TICK && chan_enable[c])
            begin
                swapped = 1'b0;
                if (blinking[c] && strobe)
                begin
                    if (phase_left[c] != '0)
                    begin
                        phase_left[c] = phase_left[c] - 16'd1;
                    end
                    if (phase_left[c] == '0)
                    begin
                        phase_left[c] = phase_on[c] ? off_ms[c] : on_ms[c];
                        lit[c]        = ~phase_on[c];
                        phase_on[c]   = ~phase_on[c];
                        swapped       = 1'b1;
                    end
                end
                if (!swapped && dimming[c] && (!blinking[c] || phase_on[c]))
                begin
                    if (pwm_left[c] != '0)
                    begin
                        pwm_left[c] = pwm_left[c] - 7'd1;
                    end
                    if (pwm_left[c] == '0)
                    begin
                        duty        = CIE_DUTY[level_idx[c]];
                        pwm_left[c] = lit[c] ? PCT_MAX - duty : duty;
                        if (pwm_left[c] != '0 && pwm_left[c] < PCT_MAX)
                        begin
                            lit[c] = ~lit[c];
                        end
                    end
                end
            end
            pins[c] = chan_enable[c] ? (lit_level ? lit[c] : ~lit[c]) : ~lit_level;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_divider = TICKS_PER_MS_RST;
            chan_enable  = CHANNEL_ENABLE_RST;
            lit_level    = 1'b1;
            prescale     = '0;
            lit          = '0;
            blinking     = '0;
            phase_on     = '0;
            dimming      = '0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                on_ms[c]      = '0;
                off_ms[c]     = '0;
                phase_left[c] = '0;
                pwm_left[c]   = '0;
                level_idx[c]  = '0;
            end
            expected_pins.delete();
            fail_total = 0;
            seen_total = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen_total++;
                if (expected_pins.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                    begin
                        $display("%0t: unexpected result, pin_levels %h", $time, m_tdata);
                    end
                end
                else
                begin
                    wanted = expected_pins.pop_front();
                    if (m_tdata !== wanted)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                        begin
                            $display("%0t: pin_levels expected %h, got %h",
                                     $time, wanted, m_tdata);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_pins(s_tdata, predicted);
                expected_pins.push_back(predicted);
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_TICKS_PER_MS:   tick_divider = pwdata[TIME_W-1:0];
                    REG_CHANNEL_ENABLE: chan_enable  = pwdata[CHAN_W-1:0];
                    REG_ON_LEVEL:       lit_level    = pwdata[0];
                    default:            ;
                endcase
            end
        end
        mismatches      <= fail_total;
        pending_results <= expected_pins.size();
        results_seen    <= seen_total;
    end

endmodule

FILE: dv/led_blink_dimming_controller_test.sv
// ============================================================================
// LED blink and dimming controller testbench
// Drives directed and random LED commands and ticks under several register
// settings with random idle bursts on both streams; the checker predicts and
// compares every result.
// ============================================================================
module led_blink_dimming_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lbdc_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_SPARE_6     = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_7     = 3'd7;
    localparam int                  WATCHDOG_LIMIT = 2000;
    localparam int                  NUM_PHASES     = 6;

    localparam logic [TIME_W-1:0] PHASE_TICKS [0:NUM_PHASES-1] =
        '{16'd2, 16'd0, 16'hFFFF, 16'd3, 16'd5, 16'd1};
    localparam logic [CHAN_W-1:0] PHASE_ENABLE [0:NUM_PHASES-1] =
        '{8'hFF, 8'hA5, 8'h5A, 8'h00, 8'hFF, 8'hFF};
    localparam logic PHASE_LEVEL [0:NUM_PHASES-1] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    localparam int PHASE_ITEMS [0:NUM_PHASES-1] = '{130, 130, 100, 40, 140, 180};

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // opcode[2:0], channel_mask[10:3], blink_on_ms[26:11],
    // blink_off_ms[42:27], brightness_level[49:43], zero fill[55:50]
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // pin_levels[7:0]
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int pending_results;
    int results_seen;
    int items_sent      = 0;
    int settings_used   = 0;
    int stall_left      = 0;
    int quiet_cycles    = 0;
    bit sender_idles    = 1'b1;
    bit receiver_idles  = 1'b1;

    led_blink_dimming_controller u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    led_blink_dimming_controller_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .pending_results (pending_results),
        .results_seen    (results_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (receiver_idles && $urandom_range(7) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(6);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("led_blink_dimming_controller: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_cmd(input logic [OPCODE_W-1:0] op,
                                                      input logic [CHAN_W-1:0]   mask,
                                                      input logic [TIME_W-1:0]   t_on,
                                                      input logic [TIME_W-1:0]   t_off,
                                                      input logic [LEVEL_W-1:0]  lvl);
        return {{(IN_DATA_W - 50){1'b0}}, lvl, t_off, t_on, mask, op};
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_command();
        int                  pick;
        int                  shape;
        logic [OPCODE_W-1:0] op;
        logic [CHAN_W-1:0]   mask;
        logic [TIME_W-1:0]   t_on;
        logic [TIME_W-1:0]   t_off;
        logic [LEVEL_W-1:0]  lvl;
        pick = $urandom_range(99);
        if (pick < 55)
            op = OP_TICK;
        else if (pick < 63)
            op = OP_ON;
        else if (pick < 69)
            op = OP_OFF;
        else if (pick < 75)
            op = OP_TOGGLE;
        else if (pick < 85)
            op = OP_BLINK;
        else if (pick < 95)
            op = OP_BRIGHTNESS;
        else
            op = ($urandom_range(1) != 0) ? OP_SPARE_6 : OP_SPARE_7;
        shape = $urandom_range(19);
        if (shape < 14)
            mask = CHAN_W'($urandom);
        else if (shape < 17)
            mask = 8'hFF;
        else
            mask = 8'h01 << $urandom_range(7);
        shape = $urandom_range(19);
        if (shape == 0)
        begin
            t_on  = '0;
            t_off = TIME_W'($urandom);
        end
        else if (shape == 1)
        begin
            t_on  = TIME_W'($urandom);
            t_off = '0;
        end
        else if (shape < 4)
        begin
            t_on  = TIME_W'($urandom);
            t_off = TIME_W'($urandom);
        end
        else
        begin
            t_on  = TIME_W'($urandom_range(1, 6));
            t_off = TIME_W'($urandom_range(1, 6));
        end
        lvl = LEVEL_W'($urandom_range(127));
        return pack_cmd(op, mask, t_on, t_off, lvl);
    endfunction

    task automatic push_command(input logic [IN_DATA_W-1:0] item);
        if (sender_idles && $urandom_range(5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_TICKS_PER_MS, 32'd1);
        settings_used++;
        push_command(pack_cmd(OP_ON, 8'hFF, 16'd0, 16'd0, 7'd0));
        push_command(pack_cmd(OP_OFF, 8'h01, 16'd0, 16'd0, 7'd0));
        push_command(pack_cmd(OP_TOGGLE, 8'hAA, 16'd0, 16'd0, 7'd0));
        push_command(pack_cmd(OP_TOGGLE, 8'hFF, 16'd0, 16'd0, 7'd0));
        push_command(pack_cmd(OP_SPARE_6, 8'hFF, 16'hFFFF, 16'hFFFF, 7'h7F));
        push_command(pack_cmd(OP_SPARE_7, 8'hFF, 16'hFFFF, 16'hFFFF, 7'h7F));
        push_command(pack_cmd(OP_BLINK, 8'h0F, 16'd1, 16'd2, 7'd0));
        push_command(pack_cmd(OP_BLINK, 8'h03, 16'd0, 16'd5, 7'd0));
        push_command(pack_cmd(OP_BLINK, 8'h04, 16'd3, 16'd0, 7'd0));
        push_command(pack_cmd(OP_BLINK, 8'h80, 16'hFFFF, 16'hFFFF, 7'd0));
        repeat (3) push_command(pack_cmd(OP_TICK, 8'h00, 16'd0, 16'd0, 7'd0));
        push_command(pack_cmd(OP_BRIGHTNESS, 8'h10, 16'd0, 16'd0, 7'd0));
        push_command(pack_cmd(OP_BRIGHTNESS, 8'h20, 16'd0, 16'd0, 7'd100));
        push_command(pack_cmd(OP_BRIGHTNESS, 8'h40, 16'd0, 16'd0, 7'd127));
        push_command(pack_cmd(OP_BRIGHTNESS, 8'h08, 16'd0, 16'd0, 7'd50));
        push_command(pack_cmd(OP_BRIGHTNESS, 8'h01, 16'd0, 16'd0, 7'd5));
        push_command(pack_cmd(OP_BRIGHTNESS, 8'h0F, 16'd0, 16'd0, 7'd1));
        repeat (4) push_command(pack_cmd(OP_TICK, 8'h00, 16'd0, 16'd0, 7'd0));
        push_command(pack_cmd(OP_ON, 8'h00, 16'd0, 16'd0, 7'd0));
        push_command(pack_cmd(OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 7'h7F));
        settle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(REG_TICKS_PER_MS, {16'd0, PHASE_TICKS[p]});
            write_reg(REG_CHANNEL_ENABLE, {24'd0, PHASE_ENABLE[p]});
            write_reg(REG_ON_LEVEL, {31'd0, PHASE_LEVEL[p]});
            settings_used++;
            for (int n = 0; n < PHASE_ITEMS[p]; n++)
            begin
                if (n % 50 == 0)
                begin
                    sender_idles   = (p != NUM_PHASES - 1) && ($urandom_range(3) != 0);
                    receiver_idles = (p != NUM_PHASES - 1) && ($urandom_range(3) != 0);
                end
                push_command(random_command());
            end
            settle();
        end

        repeat (8) @(posedge clk);
        $display("Covered %0d items under %0d register settings; %0d results checked.",
                 items_sent, settings_used, results_seen);
        if (mismatches == 0 && pending_results == 0)
        begin
            $display("led_blink_dimming_controller: match");
        end
        else
        begin
            $display("led_blink_dimming_controller: mismatch");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/lbdc_pkg.sv
rtl/led_blink_dimming_controller.sv
rtl/lbdc_checker.sv
dv/led_blink_dimming_controller_checker.sv
dv/led_blink_dimming_controller_test.sv
